// ----- rtl/fls_pkg.sv -----
// Shared types and constants for the filtering LIFO stack.
`timescale 1ns / 1ps
`default_nettype none
package fls_pkg;

  localparam logic [2:0] CMD_PUSH         = 3'd0;
  localparam logic [2:0] CMD_POP          = 3'd1;
  localparam logic [2:0] CMD_REMOVE_VALUE = 3'd2;
  localparam logic [2:0] CMD_REMOVE_EVEN  = 3'd3;
  localparam logic [2:0] CMD_CLEAR        = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic [1:0]         status;
    logic               found;
    logic [6:0]         depth_after;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_REM_VAL,
    OP_REM_EVEN,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] operand;
  } q_item_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_POP,
    ENG_SCAN
  } eng_state_t;

endpackage
`default_nettype wire

// ----- rtl/fls_front.sv -----
// Front end: accepts input items and classifies each command for the queue.
`timescale 1ns / 1ps
`default_nettype none
module fls_front
  import fls_pkg::*;
(
  input  wire logic     in_valid,
  input  wire in_item_t in_item,
  output logic          in_stall,
  output logic          enq_valid,
  output q_item_t       enq_item,
  input  wire logic     enq_full
);

  always_comb begin
    enq_item.operand = in_item.operand_value;
    unique case (in_item.cmd)
      CMD_PUSH:         enq_item.op = OP_PUSH;
      CMD_POP:          enq_item.op = OP_POP;
      CMD_REMOVE_VALUE: enq_item.op = OP_REM_VAL;
      CMD_REMOVE_EVEN:  enq_item.op = OP_REM_EVEN;
      CMD_CLEAR:        enq_item.op = OP_CLEAR;
      default:          enq_item.op = OP_NOP;
    endcase
  end

  assign enq_valid = in_valid;
  assign in_stall  = enq_full;

endmodule
`default_nettype wire

// ----- rtl/fls_queue.sv -----
// Two-entry command queue between front end and execution engine.
`timescale 1ns / 1ps
`default_nettype none
module fls_queue
  import fls_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    enq_valid,
  input  wire q_item_t enq_item,
  output logic         enq_full,
  output logic         deq_valid,
  output q_item_t      deq_item,
  input  wire logic    deq
);

  q_item_t    slot_r [2];
  logic       wptr_r;
  logic       wptr_nxt;
  logic       rptr_r;
  logic       rptr_nxt;
  logic [1:0] fill_r;
  logic [1:0] fill_nxt;
  logic       do_enq;
  logic       do_deq;

  assign enq_full  = (fill_r == 2'd2);
  assign deq_valid = (fill_r != 2'd0);
  assign deq_item  = slot_r[rptr_r];
  assign do_enq    = enq_valid && !enq_full;
  assign do_deq    = deq && deq_valid;

  always_comb begin
    wptr_nxt = do_enq ? ~wptr_r : wptr_r;
    rptr_nxt = do_deq ? ~rptr_r : rptr_r;
    fill_nxt = fill_r + {1'b0, do_enq} - {1'b0, do_deq};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_enq) begin
      slot_r[wptr_r] <= enq_item;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/fls_engine.sv -----
// Execution engine: entry store, depth counter, compaction sequencer, result register.
`timescale 1ns / 1ps
`default_nettype none
module fls_engine
  import fls_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    q_valid,
  input  wire q_item_t q_item,
  output logic         q_deq,
  output logic         out_valid,
  output out_item_t    out_item,
  input  wire logic    out_stall
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic signed [31:0] mem [STACK_DEPTH];

  eng_state_t         state_r;
  eng_state_t         state_nxt;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic [CW-1:0]      rd_r;
  logic [CW-1:0]      rd_nxt;
  logic [CW-1:0]      wr_r;
  logic [CW-1:0]      wr_nxt;
  logic signed [31:0] key_r;
  logic signed [31:0] key_nxt;
  logic               even_r;
  logic               even_nxt;
  logic               hit_r;
  logic               hit_nxt;
  logic signed [31:0] rdata_r;
  logic               out_valid_r;
  out_item_t          out_item_r;

  logic               out_free;
  logic               emit;
  out_item_t          res;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [CW-1:0]      count_m1;
  logic               full;
  logic               keep;
  logic               last;

  assign out_free  = !out_valid_r || !out_stall;
  assign count_m1  = count_r - CW'(1);
  assign full      = (count_r == CW'(STACK_DEPTH));
  assign keep      = even_r ? rdata_r[0] : (rdata_r != key_r);
  assign last      = (rd_r == count_r);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    rd_nxt           = rd_r;
    wr_nxt           = wr_r;
    key_nxt          = key_r;
    even_nxt         = even_r;
    hit_nxt          = hit_r;
    q_deq            = 1'b0;
    emit             = 1'b0;
    mem_we           = 1'b0;
    mem_waddr        = count_r[AW-1:0];
    mem_wdata        = q_item.operand;
    mem_re           = 1'b0;
    mem_raddr        = count_m1[AW-1:0];
    res.popped_value = '0;
    res.status       = STAT_OK;
    res.found        = 1'b0;

    unique case (state_r)
      ENG_IDLE: begin
        if (q_valid) begin
          unique case (q_item.op)
            OP_PUSH: begin
              if (out_free) begin
                q_deq = 1'b1;
                emit  = 1'b1;
                if (full) begin
                  res.status = STAT_FULL;
                end else begin
                  mem_we    = 1'b1;
                  count_nxt = count_r + CW'(1);
                end
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                if (out_free) begin
                  q_deq      = 1'b1;
                  emit       = 1'b1;
                  res.status = STAT_EMPTY;
                end
              end else begin
                q_deq     = 1'b1;
                mem_re    = 1'b1;
                count_nxt = count_m1;
                state_nxt = ENG_POP;
              end
            end
            OP_REM_VAL, OP_REM_EVEN: begin
              if (count_r == '0) begin
                if (out_free) begin
                  q_deq = 1'b1;
                  emit  = 1'b1;
                end
              end else begin
                q_deq     = 1'b1;
                mem_re    = 1'b1;
                mem_raddr = '0;
                rd_nxt    = CW'(1);
                wr_nxt    = '0;
                key_nxt   = q_item.operand;
                even_nxt  = (q_item.op == OP_REM_EVEN);
                hit_nxt   = 1'b0;
                state_nxt = ENG_SCAN;
              end
            end
            OP_CLEAR: begin
              if (out_free) begin
                q_deq     = 1'b1;
                emit      = 1'b1;
                count_nxt = '0;
              end
            end
            default: begin
              if (out_free) begin
                q_deq = 1'b1;
                emit  = 1'b1;
              end
            end
          endcase
        end
      end
      ENG_POP: begin
        if (out_free) begin
          emit             = 1'b1;
          res.popped_value = rdata_r;
          state_nxt        = ENG_IDLE;
        end
      end
      ENG_SCAN: begin
        if (!last || out_free) begin
          if (keep) begin
            mem_we    = 1'b1;
            mem_waddr = wr_r[AW-1:0];
            mem_wdata = rdata_r;
            wr_nxt    = wr_r + CW'(1);
          end else begin
            hit_nxt = 1'b1;
          end
          if (last) begin
            emit      = 1'b1;
            count_nxt = wr_nxt;
            res.found = !even_r && hit_nxt;
            state_nxt = ENG_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = rd_r[AW-1:0];
            rd_nxt    = rd_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = ENG_IDLE;
      end
    endcase

    res.depth_after = 7'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ENG_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_r   <= rd_nxt;
    wr_r   <= wr_nxt;
    key_r  <= key_nxt;
    even_r <= even_nxt;
    hit_r  <= hit_nxt;
    if (emit) begin
      out_item_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/filtering_lifo_stack.sv -----
// Push, clear and flagged commands pass the command queue and result register; pop also
// passes the entry store read register. Remove value and remove even read one stored entry
// per cycle through the single read port of the entry store, the last waiting on a held
// output; push and clear sustain one item per cycle unless the output stalls; pop and removal
// hold the engine until their result is written. Reset clears the depth counter, command
// queue and result valid flag; the entry store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module filtering_lifo_stack
  import fls_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire in_item_t  in_item,
  output logic           in_stall,
  output logic           out_valid,
  output out_item_t      out_item,
  input  wire logic      out_stall
);

  logic    enq_valid;
  q_item_t enq_item;
  logic    enq_full;
  logic    q_valid;
  q_item_t q_item;
  logic    q_deq;

  fls_front u_front (
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .enq_valid (enq_valid),
    .enq_item  (enq_item),
    .enq_full  (enq_full)
  );

  fls_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .enq_valid (enq_valid),
    .enq_item  (enq_item),
    .enq_full  (enq_full),
    .deq_valid (q_valid),
    .deq_item  (q_item),
    .deq       (q_deq)
  );

  fls_engine #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_deq     (q_deq),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

endmodule
`default_nettype wire

// ----- sim/fls_stack_checker.sv -----
// Checker that mirrors the filtering LIFO stack and compares every reply item.
`timescale 1ns / 1ps
module fls_stack_checker
  import fls_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire in_item_t  in_item,
  input  wire logic      in_stall,
  input  wire logic      out_valid,
  input  wire out_item_t out_item,
  input  wire logic      out_stall,
  output int             mismatches,
  output int             replies_owed
);

  logic signed [31:0] shadow_mem [STACK_DEPTH];
  int                 shadow_depth;
  out_item_t          replies_due [$];

  initial begin
    mismatches   = 0;
    replies_owed = 0;
    shadow_depth = 0;
  end

  task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic step_stack(input in_item_t it, output out_item_t res);
    int                 rd;
    int                 wr;
    logic signed [31:0] v;
    logic               drop;
    res        = '0;
    res.status = STAT_OK;
    case (it.cmd)
      CMD_PUSH: begin
        if (shadow_depth >= STACK_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          shadow_mem[shadow_depth] = it.operand_value;
          shadow_depth++;
        end
      end
      CMD_POP: begin
        if (shadow_depth == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          shadow_depth--;
          res.popped_value = shadow_mem[shadow_depth];
        end
      end
      CMD_REMOVE_VALUE, CMD_REMOVE_EVEN: begin
        wr = 0;
        for (rd = 0; rd < shadow_depth; rd++) begin
          v    = shadow_mem[rd];
          drop = (it.cmd == CMD_REMOVE_VALUE) ? (v == it.operand_value) : ~v[0];
          if (drop) begin
            if (it.cmd == CMD_REMOVE_VALUE) res.found = 1'b1;
          end else begin
            shadow_mem[wr] = v;
            wr++;
          end
        end
        shadow_depth = wr;
      end
      CMD_CLEAR: begin
        shadow_depth = 0;
      end
      default: begin
      end
    endcase
    res.depth_after = 7'(shadow_depth);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      shadow_depth = 0;
      replies_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          flag("unexpected item", out_item.popped_value, '0);
        end else begin
          want = replies_due.pop_front();
          if (out_item.popped_value !== want.popped_value)
            flag("popped_value", out_item.popped_value, want.popped_value);
          if (out_item.status !== want.status)
            flag("status", 32'(out_item.status), 32'(want.status));
          if (out_item.found !== want.found)
            flag("found", 32'(out_item.found), 32'(want.found));
          if (out_item.depth_after !== want.depth_after)
            flag("depth_after", 32'(out_item.depth_after), 32'(want.depth_after));
        end
      end
      if (in_valid && !in_stall) begin
        step_stack(in_item, want);
        replies_due.push_back(want);
      end
    end
    replies_owed = replies_due.size();
  end

endmodule

// ----- sim/tb_filtering_lifo_stack.sv -----
// Testbench top: drives commands into the filtering LIFO stack and gives the verdict.
`timescale 1ns / 1ps
module tb_filtering_lifo_stack;
  import fls_pkg::*;

  localparam int               RANDOM_ITEMS = 230;
  localparam int               HOLD_CYCLES  = 400;
  localparam int               HOLD_ITEMS   = 150;
  localparam int               LIMIT_CYCLES = 400000;
  localparam int               TAIL_CYCLES  = 100;
  localparam logic [2:0]       CMD_SPARE_LO = 3'd5;
  localparam logic [2:0]       CMD_SPARE_HI = 3'd7;
  localparam logic signed [31:0] VAL_MAX    = 32'sh7fffffff;
  localparam logic signed [31:0] VAL_MIN    = 32'sh80000000;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;
  logic      out_stall = 1'b0;
  logic      calm      = 1'b0;
  logic      hold_req  = 1'b0;
  int        cycle_count = 0;
  int        mismatches;
  int        replies_owed;

  filtering_lifo_stack dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_item (out_item),
    .out_stall(out_stall)
  );

  fls_stack_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_item     (in_item),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .out_stall   (out_stall),
    .mismatches  (mismatches),
    .replies_owed(replies_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 45);
  endfunction

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 32'(int'($urandom_range(0, 8)) - 4);
    if (r < 55) begin
      case ($urandom_range(0, 3))
        0: return VAL_MAX;
        1: return VAL_MIN;
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic offer(input logic [2:0] c, input logic signed [31:0] v);
    int gap;
    in_item  <= '{cmd: c, operand_value: v};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_replies();
    if (in_valid) in_valid <= 1'b0;
    do @(negedge clk); while (replies_owed != 0);
    @(posedge clk);
  endtask

  // receiver side: random stalls, or one long hold when asked
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        n = calm ? 0 : idle_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int         i;
    int         k;
    int         r;
    logic [2:0] c;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer(CMD_POP, '0);
    offer(CMD_REMOVE_VALUE, '0);
    offer(CMD_REMOVE_EVEN, '0);
    offer(CMD_CLEAR, '0);
    offer(CMD_PUSH, VAL_MAX);
    offer(CMD_PUSH, VAL_MIN);
    offer(CMD_PUSH, -32'sd1);
    offer(CMD_PUSH, '0);
    offer(CMD_PUSH, -32'sd2);
    offer(CMD_PUSH, 32'sd5);
    offer(CMD_PUSH, 32'sd5);
    offer(CMD_PUSH, 32'sd3);
    offer(CMD_REMOVE_VALUE, 32'sd5);
    offer(CMD_REMOVE_VALUE, 32'sd99);
    offer(CMD_REMOVE_EVEN, $urandom);
    offer(CMD_POP, $urandom);
    offer(CMD_POP, '0);
    for (k = CMD_SPARE_LO; k <= CMD_SPARE_HI; k++) offer(3'(k), $urandom);
    offer(CMD_PUSH, 32'sd4);
    offer(CMD_CLEAR, $urandom);
    offer(CMD_POP, '0);

    // hold the receiver while pushes keep coming: the stack fills and input stalls
    drain_replies();
    calm     = 1'b1;
    hold_req = 1'b1;
    for (i = 0; i < HOLD_ITEMS; i++) offer(CMD_PUSH, pick_value());
    calm = 1'b0;
    drain_replies();

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      calm = ((i / 50) % 4) == 2;
      if (i == RANDOM_ITEMS / 2) drain_replies();
      r = $urandom_range(0, 99);
      if (r < 50) c = CMD_PUSH;
      else if (r < 74) c = CMD_POP;
      else if (r < 84) c = CMD_REMOVE_VALUE;
      else if (r < 90) c = CMD_REMOVE_EVEN;
      else if (r < 94) c = CMD_CLEAR;
      else if (r < 97) c = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      else c = CMD_PUSH;
      offer(c, pick_value());
    end

    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && replies_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
